/* hw/rtl/strq_pkg.sv */
package strq_pkg;

  localparam int STAMP_W   = 32;
  localparam int FILL_W    = 7;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_DISABLED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic [STAMP_W-1:0] STAMP_NONE = '1;  // -1
  localparam logic [STAMP_W-1:0] STAMP_ZERO = '0;

  // Broadcast control from the top level to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

endpackage

/* hw/rtl/strq_cell.sv */
module strq_cell (
  input  logic                            clk,
  input  strq_pkg::cell_ctl_t             ctl,
  input  logic                            occupied,
  input  logic                            left_take,
  input  logic [strq_pkg::STAMP_W-1:0]    left_entry,
  input  logic [strq_pkg::STAMP_W-1:0]    right_entry,
  output logic                            take,
  output logic [strq_pkg::STAMP_W-1:0]    entry
);
  import strq_pkg::*;

  // An empty cell always takes; held stamps stay ascending, so the take
  // flags form a step along the chain: zeros, then ones.
  assign take = !occupied || ($signed(ctl.stamp) < $signed(entry));

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (left_take) begin
        entry <= left_entry;
      end else if (take) begin
        entry <= ctl.stamp;
      end
    end else if (ctl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

/* hw/rtl/sorted_timestamp_reorder_queue_core.sv */
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-------------------------------------
// item in  | func, stamp_in                 | taken at clk edge with start & !busy
// result   | stamp_out, status, fill        | valid for one cycle while done is high
// config   | cfg_we, cfg_wdata (enabled)    | written at clk edge with cfg_we high
//
// One item per cycle: every cell of the chain compares and shifts in the
// same cycle, so busy stays low and a new item may follow every clock.
// The result of an item shows on done in the cycle after the item is taken.
// Synchronous active-high rst clears the fill count, the enable register
// and the result strobe; cell contents are left as they are.
// The receiver cannot stall: each result is present for exactly one cycle.
module sorted_timestamp_reorder_queue_core #(
  parameter int DEPTH = strq_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func,
  input  logic [strq_pkg::STAMP_W-1:0]    stamp_in,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  output logic                            done,
  output logic [strq_pkg::STAMP_W-1:0]    stamp_out,
  output logic [1:0]                      status,
  output logic [strq_pkg::FILL_W-1:0]     fill
);
  import strq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Control state
  logic                 enabled;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // Chain wiring
  logic [STAMP_W-1:0]   entry [DEPTH];
  logic                 take  [DEPTH];
  cell_ctl_t            ctl;

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic                 do_ins;
  logic                 do_rem;
  logic [STAMP_W-1:0]   stamp_out_next;
  status_t              status_next;
  logic [31:0]          count_wide;

  // Every item completes in its own cycle; never hold off the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    do_ins         = 1'b0;
    do_rem         = 1'b0;
    count_next     = count;
    stamp_out_next = STAMP_ZERO;
    status_next    = ST_DONE;
    case (func_t'(func))
      FN_INSERT: begin
        if (!enabled) begin
          status_next = ST_DISABLED;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = accept;
          count_next = count + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (!enabled) begin
          stamp_out_next = STAMP_NONE;
          status_next    = ST_DISABLED;
        end else if (is_empty) begin
          stamp_out_next = STAMP_NONE;
          status_next    = ST_EMPTY;
        end else begin
          do_rem         = accept;
          stamp_out_next = entry[0];
          count_next     = count - CNT_W'(1);
        end
      end
      FN_CLEAR: begin
        // Clear works even while disabled.
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign ctl.ins   = do_ins;
  assign ctl.rem   = do_rem;
  assign ctl.stamp = stamp_in;

  // Build the chain: each cell sees its left neighbor's take flag and entry
  // for an insert shift, and its right neighbor's entry for a remove shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               occ;
    logic               lt;
    logic [STAMP_W-1:0] le;
    logic [STAMP_W-1:0] re;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign le = stamp_in;
    end else begin : g_mid
      assign lt = take[i-1];
      assign le = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign re = entry[i];
    end else begin : g_body
      assign re = entry[i+1];
    end

    strq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_take   (lt),
      .left_entry  (le),
      .right_entry (re),
      .take        (take[i]),
      .entry       (entry[i])
    );
  end

  // Hold the enable register; update the fill count on each taken item.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled <= cfg_wdata;
      end
      if (accept) begin
        count <= count_next;
      end
      done <= accept;
    end
  end

  assign count_wide = 32'(count_next);

  // Result payload: no reset needed, qualified by done.
  always_ff @(posedge clk) begin
    if (accept) begin
      stamp_out <= stamp_out_next;
      status    <= status_next;
      fill      <= count_wide[FILL_W-1:0];
    end
  end

  // Fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // Every taken item yields a result on the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result strobe missing");

  // A successful remove returns what was at the head of the chain.
  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    do_rem |=> (stamp_out == $past(entry[0])))
    else $error("removed stamp is not the head entry");

  // The two head cells, once both held, stay in ascending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> !($signed(entry[1]) < $signed(entry[0])))
    else $error("head of chain out of order");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import strq_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_PRINTED = 20;

  // One result of the queue, as it appears on the result ports.
  typedef struct {
    logic [STAMP_W-1:0] stamp;
    status_t            st;
    logic [FILL_W-1:0]  fill;
  } queue_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  func_t              func;
  logic [STAMP_W-1:0] stamp_in;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               done;
  logic [STAMP_W-1:0] stamp_out;
  logic [1:0]         status;
  logic [FILL_W-1:0]  fill;

  // Shadow of the queue: stamps held in ascending order, plus the enable bit.
  logic [STAMP_W-1:0] sorted_stamps[$];
  logic               model_enabled;
  queue_result_t      pending_results[$];

  int issued_count;
  int checked_count;
  int error_count;
  int stall_cycles;
  int full_drops;
  int empty_removes;
  int disabled_ops;
  int peak_fill;
  bit no_gaps;

  sorted_timestamp_reorder_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .stamp_in  (stamp_in),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .stamp_out (stamp_out),
    .status    (status),
    .fill      (fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow list and return the result it must give.
  function automatic queue_result_t predict_queue_op(func_t op, logic [STAMP_W-1:0] s);
    queue_result_t r;
    int            pos;
    r.stamp = STAMP_ZERO;
    r.st    = ST_DONE;
    case (op)
      FN_INSERT: begin
        if (!model_enabled) begin
          r.st = ST_DISABLED;
        end else if (sorted_stamps.size() >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          // go past every held stamp <= the new one, so ties stay in arrival order
          pos = 0;
          while (pos < sorted_stamps.size() && !($signed(s) < $signed(sorted_stamps[pos]))) begin
            pos++;
          end
          sorted_stamps.insert(pos, s);
        end
      end
      FN_REMOVE: begin
        if (!model_enabled) begin
          r.stamp = STAMP_NONE;
          r.st    = ST_DISABLED;
        end else if (sorted_stamps.size() == 0) begin
          r.stamp = STAMP_NONE;
          r.st    = ST_EMPTY;
        end else begin
          r.stamp = sorted_stamps.pop_front();
        end
      end
      FN_CLEAR: sorted_stamps.delete();
      default: ;
    endcase
    r.fill = FILL_W'(sorted_stamps.size());
    return r;
  endfunction

  // Print the first few mismatches, count them all.
  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Check results and predict accepted items in one process, so that the
  // order of pops and pushes within an edge is fixed.
  always @(posedge clk) begin : result_monitor
    queue_result_t want;
    if (rst) begin
      sorted_stamps.delete();
      pending_results.delete();
      model_enabled = 1'b0;
      stall_cycles  = 0;
    end else begin
      if (done) begin
        checked_count++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result stamp %0d status %0d fill %0d",
                                    $signed(stamp_out), status, fill));
        end else begin
          want = pending_results.pop_front();
          if (stamp_out !== want.stamp)
            report_mismatch($sformatf("stamp_out %0d, want %0d",
                                      $signed(stamp_out), $signed(want.stamp)));
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, want %s", status, want.st.name()));
          if (fill !== want.fill)
            report_mismatch($sformatf("fill %0d, want %0d", fill, want.fill));
        end
      end
      if (start && !busy) begin
        want = predict_queue_op(func, stamp_in);
        pending_results.push_back(want);
        case (want.st)
          ST_FULL:     full_drops++;
          ST_EMPTY:    empty_removes++;
          ST_DISABLED: disabled_ops++;
          default: ;
        endcase
        if (sorted_stamps.size() > peak_fill) peak_fill = sorted_stamps.size();
      end
      if (cfg_we) model_enabled = cfg_wdata;
      if (done || (start && !busy) || cfg_we) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Present one item after a random gap and hold it until taken; leave start
  // high so a following item can go out back to back.
  task automatic send_item(input func_t op, input logic [STAMP_W-1:0] s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    func     <= op;
    stamp_in <= s;
    do @(posedge clk); while (busy !== 1'b0);
    issued_count++;
  endtask

  // Stop sending and hold until every issued item has produced its result.
  task automatic drain_results();
    start <= 1'b0;
    wait (checked_count >= issued_count);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_enable_reg(input logic value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
      1:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;  // many ties around zero
      default: return $urandom();
    endcase
  endfunction

  function automatic func_t pick_func(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FN_INSERT;
    if (r < 96) return FN_REMOVE;
    if (r < 98) return FN_CLEAR;
    return FN_NOP;
  endfunction

  // Enable is still at its reset value: inserts and removes must be ignored.
  task automatic test_disabled_after_reset();
    send_item(FN_INSERT, 32'h7FFF_FFFF);
    send_item(FN_REMOVE, $urandom());
    send_item(FN_CLEAR, STAMP_ZERO);
    send_item(FN_NOP, 32'h8000_0000);
    send_item(FN_INSERT, 32'h8000_0000);
  endtask

  task automatic test_directed_ops();
    write_enable_reg(1'b1);
    send_item(FN_REMOVE, $urandom());     // remove from an empty list
    send_item(FN_INSERT, 32'h7FFF_FFFF);
    send_item(FN_INSERT, 32'h8000_0000);
    send_item(FN_INSERT, STAMP_ZERO);
    send_item(FN_INSERT, STAMP_NONE);
    send_item(FN_INSERT, 32'd5);
    send_item(FN_INSERT, 32'd5);          // equal stamps
    send_item(FN_INSERT, STAMP_NONE);
    send_item(FN_NOP, 32'hFFFF_0000);     // unused code does nothing
    repeat (4) send_item(FN_REMOVE, $urandom());
    send_item(FN_CLEAR, STAMP_ZERO);      // clear a non-empty list
    send_item(FN_REMOVE, $urandom());
    send_item(FN_CLEAR, STAMP_ZERO);      // clear an empty list
    send_item(FN_INSERT, 32'd1);
    send_item(FN_REMOVE, $urandom());
  endtask

  task automatic test_full_list();
    repeat (LIST_DEPTH) send_item(FN_INSERT, rand_stamp());
    repeat (2) send_item(FN_INSERT, rand_stamp());   // dropped as full
    write_enable_reg(1'b0);
    send_item(FN_INSERT, rand_stamp());              // disabled wins over full
    send_item(FN_REMOVE, $urandom());
    send_item(FN_CLEAR, STAMP_ZERO);                 // empties even while disabled
    write_enable_reg(1'b1);
    send_item(FN_REMOVE, $urandom());
    no_gaps = 1'b1;
    repeat (LIST_DEPTH) send_item(FN_INSERT, rand_stamp());
    no_gaps = 1'b0;
    repeat (LIST_DEPTH + 1) send_item(FN_REMOVE, $urandom());
  endtask

  // Two filling phases come before each draining one, with random gaps
  // or none, a disabled stretch and one full pause.
  task automatic test_random_traffic();
    int n;
    int ins_pct;
    for (int ph = 0; ph < 12; ph++) begin
      ins_pct = (ph % 3 == 2) ? $urandom_range(10, 40) : $urandom_range(55, 90);
      no_gaps = ($urandom_range(0, 2) == 0);
      n       = $urandom_range(30, 60);
      if (ph == 5) write_enable_reg(1'b0);
      if (ph == 6) write_enable_reg(1'b1);
      if (ph == 8) drain_results();
      repeat (n) send_item(pick_func(ins_pct), rand_stamp());
    end
    no_gaps = 1'b0;
  endtask

  initial begin : run
    rst       <= 1'b1;
    start     <= 1'b0;
    func      <= FN_NOP;
    stamp_in  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 1'b0;
    no_gaps   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_disabled_after_reset();
    test_directed_ops();
    test_full_list();
    test_random_traffic();

    drain_results();
    repeat (4) @(posedge clk);
    while (pending_results.size() > 0) begin
      void'(pending_results.pop_front());
      report_mismatch("result never arrived");
    end

    $display("summary: %0d items sent, peak fill %0d of %0d",
             issued_count, peak_fill, LIST_DEPTH);
    $display("summary: %0d full drops, %0d empty removes, %0d disabled ops, %0d errors",
             full_drops, empty_removes, disabled_ops, error_count);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* sorted_timestamp_reorder_queue_core.f */
hw/rtl/strq_pkg.sv
hw/rtl/strq_cell.sv
hw/rtl/sorted_timestamp_reorder_queue_core.sv
bench/testbench.sv
